// File: rtl/olpd_pkg.sv
// Shared constants and types for the open-loop phase duty block.
// Depends on nothing; the design files import it.
package olpd_pkg;

   localparam int TRIG_BITS_DEFAULT = 16;

   // Pipeline depths of the sine unit and of the duty divider.
   localparam int SINE_LATENCY = 6;
   localparam int DIV_LATENCY  = 17;

   // Odd Taylor coefficients in Q30, Horner order from the ninth power down.
   localparam logic signed [32:0] SINE_COEF [0:4] = '{
      33'sd172272, 33'sd5026995, 33'sd85569306, 33'sd693598669, 33'sd1686629713
   };

   // sqrt(3) in Q20, as a signed operand.
   localparam logic signed [21:0] SQRT3_Q20 = 22'sd1816187;

   localparam logic [14:0] SUPPLY_LIMIT_RESET = 15'd12000;

   // Register index taken from the word address.
   localparam logic CSR_SUPPLY_LIMIT = 1'b0;

   localparam logic [15:0] DUTY_FULL = 16'd32768;

   typedef struct packed {
      logic [15:0] duty;
      logic        clamp;
   } duty_result_type;

endpackage

// File: rtl/olpd_sine.sv
// Pipelined fixed-point sine of a 16-bit phase (Horner over one quarter wave).
// Depends on olpd_pkg.
module olpd_sine import olpd_pkg::*; #(
   parameter int TRIG_BITS = TRIG_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [15:0]                   phase,
   output logic signed [TRIG_BITS+1:0]   value
);

   logic [14:0] u_ff [0:4];
   logic [30:0] x2_ff [0:3];
   logic        neg_ff [0:4];
   logic signed [32:0] t_ff [1:4];
   logic signed [TRIG_BITS+1:0] value_ff;

   logic [14:0] u_in;
   logic [29:0] usq;

   // Fold the phase into the first quadrant.
   always_comb begin
      u_in = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      usq  = u_in * u_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff[0]   <= u_in;
         x2_ff[0]  <= {usq[28:0], 2'b00};
         neg_ff[0] <= phase[15];
      end
   end

   for (genvar k = 1; k <= 4; k++) begin : g_horner
      logic signed [32:0] tp;
      logic signed [64:0] prod;
      logic signed [64:0] prod_sh;
      logic signed [32:0] t_in;
      if (k == 1) begin : g_first
         assign tp = SINE_COEF[0];
      end else begin : g_next
         assign tp = t_ff[k-1];
      end
      always_comb begin
         prod    = $signed({2'b00, x2_ff[k-1]}) * tp;
         prod_sh = prod >>> 30;
         t_in    = SINE_COEF[k] - prod_sh[32:0];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            t_ff[k]   <= t_in;
            u_ff[k]   <= u_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            if (k < 4) begin
               x2_ff[k < 4 ? k : 3] <= x2_ff[k-1];
            end
         end
      end
   end

   logic signed [48:0] mprod;
   logic signed [48:0] mprod_sh;
   logic signed [34:0] mag;
   logic signed [34:0] rnd;
   logic signed [TRIG_BITS+1:0] mag_lim;
   logic signed [TRIG_BITS+1:0] value_in;

   always_comb begin
      mprod    = $signed({1'b0, u_ff[4]}) * t_ff[4];
      mprod_sh = mprod >>> 14;
      mag      = mprod_sh[34:0];
      if (mag < 0) begin
         mag = '0;
      end
      rnd = (mag + (35'sd1 <<< (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
      if (rnd > (35'sd1 <<< TRIG_BITS)) begin
         rnd = 35'sd1 <<< TRIG_BITS;
      end
      mag_lim  = rnd[TRIG_BITS+1:0];
      value_in = neg_ff[4] ? -mag_lim : mag_lim;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: rtl/olpd_div.sv
// Clamp and pipelined restoring division of one phase numerator into a Q15 duty.
// Depends on olpd_pkg.
module olpd_div import olpd_pkg::*; #(
   parameter int TRIG_BITS = TRIG_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [TRIG_BITS+39:0] numer,
   input  logic [14:0]                  dm,
   output duty_result_type              result
);

   localparam int NW = TRIG_BITS + 40;

   logic [14:0] r_ff    [0:16];
   logic [15:0] qm_ff   [0:16];
   logic        neg_ff  [0:16];
   logic        over_ff [0:16];

   logic signed [NW-1:0] dm_w;
   logic signed [NW-1:0] sum;
   logic signed [NW-1:0] m;
   logic                 over_in;

   // Rounding half up folds into the numerator; the low bits of the
   // denominator are a power of two and drop out as a shift.
   always_comb begin
      dm_w    = NW'($signed({1'b0, dm}));
      over_in = numer > (dm_w <<< (TRIG_BITS + 22));
      sum     = numer + (dm_w <<< (TRIG_BITS + 6));
      m       = sum >>> (TRIG_BITS + 7);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0]    <= m[30:16];
         qm_ff[0]   <= m[15:0];
         neg_ff[0]  <= numer[NW-1];
         over_ff[0] <= over_in;
      end
   end

   for (genvar k = 1; k <= 16; k++) begin : g_step
      logic [15:0] rs;
      logic        ge;
      logic [15:0] diff;
      always_comb begin
         rs   = {r_ff[k-1], qm_ff[k-1][15]};
         ge   = rs >= {1'b0, dm};
         diff = rs - {1'b0, dm};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[k]    <= ge ? diff[14:0] : rs[14:0];
            qm_ff[k]   <= {qm_ff[k-1][14:0], ge};
            neg_ff[k]  <= neg_ff[k-1];
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   always_comb begin
      if (neg_ff[16]) begin
         result.duty = '0;
      end else if (over_ff[16]) begin
         result.duty = DUTY_FULL;
      end else begin
         result.duty = qm_ff[16];
      end
      result.clamp = neg_ff[16] | over_ff[16];
   end

endmodule

// File: rtl/open_loop_phase_duty.sv
// Top level of the open-loop phase duty block: CSR, transform pipeline, duty dividers.
// Depends on olpd_pkg, olpd_sine and olpd_div.
//
// The block turns a quadrature voltage request and an electrical angle into three
// phase duties in Q15, with the direct axis voltage held at zero. One request is
// taken every clock cycle unless a held result stalls the pipeline. Each request passes
// through the sine and cosine units (one Horner multiply per stage), then the
// inverse Park and Clarke products and sums, and then a duty divider per phase,
// which clamps and then finds one quotient bit per stage. The whole pipeline
// advances as one; when a result is offered and not taken, every stage holds,
// so nothing is lost or repeated, and the request side is ready again as soon
// as the result is taken. The supply limit register sits at byte address 0 and
// may only be changed while no request is in flight; a value of zero acts as one.
module open_loop_phase_duty import olpd_pkg::*; #(
   parameter int TRIG_BITS = TRIG_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_quad_voltage,
   input  logic [15:0]        req_elec_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_duty_a,
   output logic [15:0]        rsp_duty_b,
   output logic [15:0]        rsp_duty_c,
   output logic               rsp_clamped,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NW      = TRIG_BITS + 40;
   localparam int LATENCY = SINE_LATENCY + 3 + DIV_LATENCY;

   // Configuration register.
   logic [14:0] supply_limit_ff;
   logic [14:0] supply_limit_in;
   logic [14:0] dm;

   always_comb begin
      supply_limit_in = supply_limit_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_SUPPLY_LIMIT)) begin
         supply_limit_in = pwdata[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_limit_ff <= SUPPLY_LIMIT_RESET;
      end else begin
         supply_limit_ff <= supply_limit_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SUPPLY_LIMIT) ? {17'b0, supply_limit_ff} : '0;
   assign dm     = (supply_limit_ff == '0) ? 15'd1 : supply_limit_ff;

   // Pipeline advance: everything moves unless a finished result is held.
   logic enable;
   logic valid_ff [0:LATENCY-1];

   assign enable    = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Sine and cosine of the angle; cosine is the sine a quarter turn ahead.
   logic signed [TRIG_BITS+1:0] sin_val;
   logic signed [TRIG_BITS+1:0] cos_val;

   olpd_sine #(.TRIG_BITS(TRIG_BITS)) u_sin (
      .clock  (clock),
      .enable (enable),
      .phase  (req_elec_angle),
      .value  (sin_val)
   );

   olpd_sine #(.TRIG_BITS(TRIG_BITS)) u_cos (
      .clock  (clock),
      .enable (enable),
      .phase  (16'(req_elec_angle + 16'd16384)),
      .value  (cos_val)
   );

   // The voltage request travels beside the sine units.
   logic signed [15:0] uq_ff [0:SINE_LATENCY-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         uq_ff[0] <= req_quad_voltage;
         for (int i = 1; i < SINE_LATENCY; i++) begin
            uq_ff[i] <= uq_ff[i-1];
         end
      end
   end

   // Inverse Park: alpha = -uq*sin, beta = uq*cos, exact in Q(TRIG_BITS).
   logic signed [TRIG_BITS+17:0] alpha_ff, beta_ff, alpha_in, beta_in;
   logic signed [15:0]           uq7_ff;

   always_comb begin
      alpha_in = -(uq_ff[SINE_LATENCY-1] * sin_val);
      beta_in  = uq_ff[SINE_LATENCY-1] * cos_val;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
         uq7_ff   <= uq_ff[SINE_LATENCY-1];
      end
   end

   // Scale beta by sqrt(3) in its own stage.
   logic signed [NW-1:0]         s3b_ff, s3b_in;
   logic signed [TRIG_BITS+17:0] alpha8_ff;
   logic signed [15:0]           uq8_ff;

   assign s3b_in = beta_ff * SQRT3_Q20;

   always_ff @(posedge clock) begin
      if (enable) begin
         s3b_ff    <= s3b_in;
         alpha8_ff <= alpha_ff;
         uq8_ff    <= uq7_ff;
      end
   end

   // Inverse Clarke, with twice each phase voltage plus the offset term, all in
   // Q(TRIG_BITS+20) so the duty numerators are exact.
   logic signed [NW-1:0] n2a_ff, n2b_ff, n2c_ff;
   logic signed [NW-1:0] n2a_in, n2b_in, n2c_in;
   logic signed [NW-1:0] a20, uqt;

   always_comb begin
      a20    = NW'(alpha8_ff) <<< 20;
      uqt    = NW'(uq8_ff) <<< (TRIG_BITS + 21);
      n2a_in = (NW'(alpha8_ff) <<< 21) + uqt;
      n2b_in = s3b_ff - a20 + uqt;
      n2c_in = -a20 - s3b_ff + uqt;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n2a_ff <= n2a_in;
         n2b_ff <= n2b_in;
         n2c_ff <= n2c_in;
      end
   end

   // One divider per phase.
   duty_result_type res_a, res_b, res_c;

   olpd_div #(.TRIG_BITS(TRIG_BITS)) u_div_a (
      .clock (clock), .enable (enable), .numer (n2a_ff), .dm (dm), .result (res_a)
   );

   olpd_div #(.TRIG_BITS(TRIG_BITS)) u_div_b (
      .clock (clock), .enable (enable), .numer (n2b_ff), .dm (dm), .result (res_b)
   );

   olpd_div #(.TRIG_BITS(TRIG_BITS)) u_div_c (
      .clock (clock), .enable (enable), .numer (n2c_ff), .dm (dm), .result (res_c)
   );

   assign rsp_duty_a  = res_a.duty;
   assign rsp_duty_b  = res_b.duty;
   assign rsp_duty_c  = res_c.duty;
   assign rsp_clamped = res_a.clamp | res_b.clamp | res_c.clamp;

endmodule

// File: rtl/olpd_checker.sv
// Port-level checks for the open-loop phase duty block, bound to its top level.
// Depends on open_loop_phase_duty.
module olpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [15:0] req_quad_voltage,
   input logic [15:0]        req_elec_angle,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [15:0]        rsp_duty_a,
   input logic [15:0]        rsp_duty_b,
   input logic [15:0]        rsp_duty_c,
   input logic               rsp_clamped,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [2:0]         paddr,
   input logic [31:0]        pwdata,
   input logic [31:0]        prdata,
   input logic               pready
);

   // A held result must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_a)
         && $stable(rsp_duty_b) && $stable(rsp_duty_c) && $stable(rsp_clamped))
      else $error("result changed while stalled");

   // No request is taken while the result is held.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   // Duties never exceed full scale.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_a <= 16'd32768 && rsp_duty_b <= 16'd32768
         && rsp_duty_c <= 16'd32768)
      else $error("duty above full scale");

   // A write to the supply limit reads back on the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr == 3'd0
         ##1 paddr == 3'd0 |-> prdata[14:0] == $past(pwdata[14:0]))
      else $error("supply limit readback mismatch");

endmodule

bind open_loop_phase_duty olpd_checker u_olpd_checker (.*);
